>>> src/btm_pkg.sv
package btm_pkg;

   localparam int SINE_DEPTH_DEFAULT = 1024;
   localparam int PHASE_BITS_DEFAULT = 32;

   localparam int SAMPLE_W = 16;
   localparam int STEP_W   = 32;
   localparam int LENGTH_W = 24;
   localparam int VOLUME_W = 8;
   localparam int AMP_W    = 15;
   localparam int MAG_W    = 15;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_BEEP   = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                    cmd;
      logic signed [SAMPLE_W-1:0] sample;
      logic [STEP_W-1:0]          beep_step;
      logic [LENGTH_W-1:0]        beep_length;
      logic [VOLUME_W-1:0]        beep_volume;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mixed;
      logic                       tone_on;
   } rsp_payload_type;

endpackage

>>> src/btm_req_if.sv
interface btm_req_if import btm_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> src/btm_rsp_if.sv
interface btm_rsp_if import btm_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> src/btm_in_reg.sv
module btm_in_reg import btm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   btm_req_if.sink         req,
   input  logic            take,
   output logic            held_valid,
   output req_payload_type held_item
);

   logic            valid_ff;
   logic            valid_in;
   req_payload_type item_ff;
   logic            load;

   assign req.ready = !valid_ff || take;
   assign load      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req.payload;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

>>> src/btm_tone_core.sv
module btm_tone_core import btm_pkg::*; #(
   parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT,
   parameter int PHASE_BITS       = PHASE_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  req_payload_type item,
   output rsp_payload_type result
);

   // The table depth must be a power of two, which the block does not check; the index is the top bits of the phase.
   localparam int IDX_BITS = $clog2(SINE_TABLE_DEPTH);
   localparam int QTR_BITS = IDX_BITS - 2;
   localparam int QUARTER  = SINE_TABLE_DEPTH / 4;
   localparam int VOL_N    = 1 << VOLUME_W;

   function automatic logic [MAG_W-1:0] sine_mag(input int k, input logic odd);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t1;
      longint unsigned t2;
      longint unsigned s;
      longint unsigned mag;
      x = ((longint'(k) * 4) << 16) / SINE_TABLE_DEPTH;
      if (odd) begin
         x = 65536 - x;
      end
      x2 = (x * x) >> 16;
      t1 = 42334 - ((5223 * x2) >> 16);
      t2 = 102944 - ((t1 * x2) >> 16);
      s  = (x * t2) >> 16;
      if (s > 65536) begin
         s = 65536;
      end
      mag = (s * 32767 + 32768) >> 16;
      return MAG_W'(mag);
   endfunction

   function automatic logic [AMP_W-1:0] amp_entry(input int v);
      return AMP_W'((32767 * v) / 255);
   endfunction

   logic [MAG_W-1:0] mag_even [QUARTER];
   logic [MAG_W-1:0] mag_odd  [QUARTER];
   logic [AMP_W-1:0] amp_rom  [VOL_N];

   for (genvar g = 0; g < QUARTER; g++) begin : g_sine
      assign mag_even[g] = sine_mag(g, 1'b0);
      assign mag_odd[g]  = sine_mag(g, 1'b1);
   end

   for (genvar v = 0; v < VOL_N; v++) begin : g_amp
      assign amp_rom[v] = amp_entry(v);
   end

   logic [PHASE_BITS-1:0] phase_ff,  phase_in;
   logic [PHASE_BITS-1:0] step_ff,   step_in;
   logic [LENGTH_W-1:0]   left_ff,   left_in;
   logic [AMP_W-1:0]      amp_ff,    amp_in;
   logic                  active_ff, active_in;

   logic [IDX_BITS-1:0]        idx;
   logic [1:0]                 quad;
   logic [QTR_BITS-1:0]        k;
   logic [MAG_W-1:0]           mag;
   logic [AMP_W+MAG_W-1:0]     prod;
   logic [MAG_W-2:0]           tone_half_mag;
   logic signed [SAMPLE_W-1:0] tone_half;
   logic signed [SAMPLE_W:0]   smp_ext;
   logic signed [SAMPLE_W-1:0] smp_half;
   logic signed [SAMPLE_W-1:0] mix_sum;
   logic                       mixing;

   assign idx  = phase_ff[PHASE_BITS-1 -: IDX_BITS];
   assign quad = idx[IDX_BITS-1 -: 2];
   assign k    = idx[QTR_BITS-1:0];
   assign mag  = quad[0] ? mag_odd[k] : mag_even[k];
   assign prod = AMP_W'(amp_ff) * MAG_W'(mag);

   // Halving truncates towards zero on both the tone and the sample.
   assign tone_half_mag = prod[AMP_W+MAG_W-1 -: MAG_W-1];
   assign tone_half     = quad[1] ? -$signed(SAMPLE_W'(tone_half_mag))
                                  : $signed(SAMPLE_W'(tone_half_mag));
   assign smp_ext  = $signed({item.sample[SAMPLE_W-1], item.sample})
                   + $signed({{SAMPLE_W{1'b0}}, item.sample[SAMPLE_W-1]});
   assign smp_half = smp_ext[SAMPLE_W:1];
   assign mix_sum  = smp_half + tone_half;

   assign mixing         = active_ff && (left_ff != '0);
   assign result.mixed   = mixing ? mix_sum : item.sample;
   assign result.tone_on = mixing;

   always_comb begin
      phase_in  = phase_ff;
      step_in   = step_ff;
      left_in   = left_ff;
      amp_in    = amp_ff;
      active_in = active_ff;
      if (fire) begin
         if (item.cmd == CMD_BEEP) begin
            if (!active_ff) begin
               phase_in  = '0;
               step_in   = item.beep_step[PHASE_BITS-1:0];
               left_in   = item.beep_length;
               amp_in    = amp_rom[item.beep_volume];
               active_in = 1'b1;
            end
         end else if (active_ff) begin
            if (left_ff == '0) begin
               active_in = 1'b0;
            end else begin
               phase_in = phase_ff + step_ff;
               left_in  = left_ff - LENGTH_W'(1);
               if (left_ff == LENGTH_W'(1)) begin
                  active_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         step_ff   <= '0;
         left_ff   <= '0;
         amp_ff    <= '0;
         active_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         step_ff   <= step_in;
         left_ff   <= left_in;
         amp_ff    <= amp_in;
         active_ff <= active_in;
      end
   end

endmodule

>>> src/btm_out_reg.sv
module btm_out_reg import btm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  rsp_payload_type result,
   btm_rsp_if.source       rsp,
   output logic            stall
);

   logic            valid_ff;
   logic            valid_in;
   rsp_payload_type payload_ff;

   assign stall = valid_ff && !rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         payload_ff <= result;
      end
   end

   assign rsp.valid   = valid_ff;
   assign rsp.payload = payload_ff;

endmodule

>>> src/beep_tone_mixer.sv
// Beep tone mixer: adds a sine beep to a stream of 16-bit audio samples.
// The req_ch channel carries items of two kinds. A sample item gives exactly
// one result on rsp_ch; a start-beep item loads the phase step, the length
// in samples and the volume, and gives no result. A start-beep item that
// arrives while a beep is still sounding is dropped.
// While a beep sounds, each result is half the sample plus half the tone and
// tone_on is high; otherwise the sample passes through unchanged.
// An item goes into an input register on its transfer, and its result is
// written to the output register when the item leaves the input register;
// a sample item leaves only while the output register is not stalled.
// One item is taken per cycle while the output is not stalled. The sine
// lookup, the amplitude multiply and the sum are combinational in between.
// A synchronous reset empties both registers and ends any beep, with the
// phase, step, length and amplitude cleared to zero.
// When the receiver holds rsp_ch.ready low, the result stays in the output
// register; one more item waits in the input register, after which req_ch
// ready falls until the result has been taken. A start-beep item in the
// input register does not wait on the receiver.
module beep_tone_mixer import btm_pkg::*; #(
   parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT,
   parameter int PHASE_BITS       = PHASE_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   btm_req_if.sink   req_ch,
   btm_rsp_if.source rsp_ch
);

   logic            held_valid;
   req_payload_type held_item;
   rsp_payload_type result;
   logic            stall;
   logic            fire;
   logic            load;

   assign fire = held_valid && ((held_item.cmd == CMD_BEEP) || !stall);
   assign load = fire && (held_item.cmd == CMD_SAMPLE);

   btm_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .take       (fire),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   btm_tone_core #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .PHASE_BITS       (PHASE_BITS)
   ) u_tone_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (held_item),
      .result (result)
   );

   btm_out_reg u_out_reg (
      .clock  (clock),
      .reset  (reset),
      .load   (load),
      .result (result),
      .rsp    (rsp_ch),
      .stall  (stall)
   );

endmodule

>>> src/btm_checker.sv
module btm_checker import btm_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // A receiver that takes every result never holds back the sender.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ready || !rsp_valid) |-> req_ready)
      else $error("input not ready although the output is free");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown straight after reset");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result withdrawn before its transfer");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_payload))
      else $error("result changed while stalled");

endmodule

bind beep_tone_mixer btm_checker u_btm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);

>>> sim/beep_tone_mixer_tb.sv
`timescale 1ns / 100ps

module beep_tone_mixer_tb;
   import btm_pkg::*;

   localparam int TABLE_DEPTH = SINE_DEPTH_DEFAULT;
   localparam int PHASE_W     = PHASE_BITS_DEFAULT;
   localparam longint unsigned PHASE_MASK = (64'd1 << PHASE_W) - 64'd1;
   localparam int RANDOM_ITEMS = 1500;
   localparam int HOLD_CYCLES  = 80;
   localparam int STALL_LIMIT  = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   btm_req_if req_bus ();
   btm_rsp_if rsp_bus ();

   beep_tone_mixer #(
      .SINE_TABLE_DEPTH(TABLE_DEPTH),
      .PHASE_BITS(PHASE_W)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus)
   );

   always #4 clock = ~clock;

   req_payload_type pending_items[$];
   rsp_payload_type expected_mix[$];
   int total_items = 0;
   int req_accepted = 0;
   int error_count = 0;
   int idle_cycles = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;
   int results_seen = 0;
   int tone_results = 0;
   int beeps_started = 0;
   int beeps_dropped = 0;

   // Tone generator state as the block should hold it.
   logic [31:0] phase_acc = '0;
   logic [31:0] beep_step_reg = '0;
   logic [23:0] beep_left = '0;
   logic beep_on = 1'b0;
   int unsigned beep_amp = 0;

   function automatic int stage_of(int n);
      if (total_items == 0) return 0;
      return (n * 3) / total_items;
   endfunction

   // Signed Q1.15 sine value for one table index, built from a quarter-wave polynomial.
   function automatic int sine_q15(longint unsigned idx);
      longint unsigned four, quad, r, x, x2, t1, t2, s, mag;
      four = idx * 4;
      quad = four / TABLE_DEPTH;
      r = four - quad * TABLE_DEPTH;
      x = (r << 16) / TABLE_DEPTH;
      if (quad[0]) x = 65536 - x;
      x2 = (x * x) >> 16;
      t1 = 42334 - ((5223 * x2) >> 16);
      t2 = 102944 - ((t1 * x2) >> 16);
      s = (x * t2) >> 16;
      if (s > 65536) s = 65536;
      mag = (s * 32767 + 32768) >> 16;
      if (quad[1]) return -int'(mag);
      return int'(mag);
   endfunction

   task automatic predict_mix(input req_payload_type it);
      longint unsigned idx;
      int s_val, mag, tone, mixed_val;
      rsp_payload_type r;
      if (it.cmd == CMD_BEEP) begin
         if (!beep_on) begin
            beep_step_reg = 32'(longint'(it.beep_step) & PHASE_MASK);
            beep_left = it.beep_length;
            beep_amp = (32767 * it.beep_volume) / 255;
            phase_acc = '0;
            beep_on = 1'b1;
            beeps_started++;
         end else begin
            beeps_dropped++;
         end
         return;
      end
      r.mixed = it.sample;
      r.tone_on = 1'b0;
      if (beep_on) begin
         if (beep_left == 0) begin
            beep_on = 1'b0;
         end else begin
            idx = ((longint'(phase_acc) & PHASE_MASK) * TABLE_DEPTH) >> PHASE_W;
            s_val = sine_q15(idx);
            mag = (s_val < 0) ? -s_val : s_val;
            tone = int'((beep_amp * mag) >> 15);
            if (s_val < 0) tone = -tone;
            mixed_val = int'(it.sample) / 2 + tone / 2;
            r.mixed = 16'(mixed_val);
            r.tone_on = 1'b1;
            phase_acc = 32'((longint'(phase_acc) + beep_step_reg) & PHASE_MASK);
            beep_left = beep_left - 24'd1;
            if (beep_left == 0) beep_on = 1'b0;
         end
      end
      expected_mix.push_back(r);
   endtask

   task automatic queue_item(input cmd_type cmd, input logic [15:0] smp,
                             input logic [31:0] step, input logic [23:0] len,
                             input logic [7:0] vol);
      req_payload_type it;
      it.cmd = cmd;
      it.sample = smp;
      it.beep_step = step;
      it.beep_length = len;
      it.beep_volume = vol;
      pending_items.push_back(it);
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(11))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'hffff;
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic queue_sample();
      queue_item(CMD_SAMPLE, pick_sample(), $urandom(), 24'($urandom()), 8'($urandom()));
   endtask

   task automatic queue_noise_beep();
      queue_item(CMD_BEEP, 16'($urandom()), $urandom(), 24'($urandom()), 8'($urandom()));
   endtask

   // Stimulus driver.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.payload <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_mix(req_bus.payload);
            req_accepted <= req_accepted + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_items.size() > 0 &&
                $urandom_range(99) >= (stage_of(req_accepted) == 0 ? 14 :
                                       stage_of(req_accepted) == 1 ? 75 : 0)) begin
               req_bus.valid <= 1'b1;
               req_bus.payload <= pending_items.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result receiver, with one long hold-off when the last stage begins.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && stage_of(req_accepted) == 2) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= (stage_of(req_accepted) == 0 ? 75 :
                                                  stage_of(req_accepted) == 1 ? 14 : 0));
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (rsp_bus.payload.tone_on) tone_results++;
         if (expected_mix.size() == 0) begin
            $error("Result transfer with no expected result: mixed %0d tone_on %0b",
                   rsp_bus.payload.mixed, rsp_bus.payload.tone_on);
            error_count++;
         end else begin
            want = expected_mix.pop_front();
            if (rsp_bus.payload.mixed !== want.mixed) begin
               $error("mixed: expected %0d, got %0d", want.mixed, rsp_bus.payload.mixed);
               error_count++;
            end
            if (rsp_bus.payload.tone_on !== want.tone_on) begin
               $error("tone_on: expected %0b, got %0b", want.tone_on,
                      rsp_bus.payload.tone_on);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("Run stalled for %0d cycles with %0d results outstanding.",
               STALL_LIMIT, expected_mix.size());
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int counted, len, n, drop_at;
      logic [7:0] vol;
      logic [31:0] step;

      // Directed part.
      queue_item(CMD_SAMPLE, 16'h0000, 32'h0, 24'h0, 8'h0);
      queue_item(CMD_SAMPLE, 16'h8000, 32'h0, 24'h0, 8'h0);
      queue_item(CMD_SAMPLE, 16'h7fff, 32'h0, 24'h0, 8'h0);
      queue_item(CMD_SAMPLE, 16'hffff, 32'h0, 24'h0, 8'h0);
      queue_item(CMD_BEEP, 16'h0, 32'h4000_0000, 24'd6, 8'd255);
      queue_item(CMD_BEEP, 16'hffff, 32'hffff_ffff, 24'hff_ffff, 8'd0);
      queue_item(CMD_SAMPLE, 16'h7fff, 32'h0, 24'h0, 8'h0);
      queue_item(CMD_SAMPLE, 16'h8000, 32'h0, 24'h0, 8'h0);
      queue_item(CMD_SAMPLE, 16'h7fff, 32'h0, 24'h0, 8'h0);
      queue_item(CMD_SAMPLE, 16'h8000, 32'h0, 24'h0, 8'h0);
      queue_item(CMD_SAMPLE, 16'h0001, 32'h0, 24'h0, 8'h0);
      queue_item(CMD_SAMPLE, 16'hffff, 32'h0, 24'h0, 8'h0);
      queue_item(CMD_SAMPLE, 16'h0005, 32'h0, 24'h0, 8'h0);
      queue_item(CMD_BEEP, 16'h0, 32'h1234_5678, 24'd0, 8'd128);
      queue_item(CMD_SAMPLE, 16'd100, 32'h0, 24'h0, 8'h0);
      queue_item(CMD_SAMPLE, 16'hfff9, 32'h0, 24'h0, 8'h0);
      queue_item(CMD_BEEP, 16'h0, 32'hffff_ffff, 24'd3, 8'd0);
      queue_item(CMD_SAMPLE, 16'h8000, 32'h0, 24'h0, 8'h0);
      queue_item(CMD_SAMPLE, 16'h7fff, 32'h0, 24'h0, 8'h0);
      queue_item(CMD_SAMPLE, 16'h0003, 32'h0, 24'h0, 8'h0);
      queue_item(CMD_BEEP, 16'h0, 32'h0000_0001, 24'd2, 8'd255);
      queue_item(CMD_SAMPLE, 16'h8001, 32'h0, 24'h0, 8'h0);
      queue_item(CMD_SAMPLE, 16'h7ffe, 32'h0, 24'h0, 8'h0);
      queue_item(CMD_SAMPLE, 16'h1234, 32'h0, 24'h0, 8'h0);

      // Random part: mostly complete beeps with their samples, the rest noise.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if ($urandom_range(9) < 8) begin
            if ($urandom_range(19) == 0) len = 0;
            else if ($urandom_range(14) == 0) len = $urandom_range(300, 60);
            else len = $urandom_range(40, 1);
            if ($urandom_range(7) == 0) vol = $urandom_range(1) ? 8'd255 : 8'd0;
            else vol = 8'($urandom());
            step = ($urandom_range(3) == 0) ? 32'($urandom_range(32'h0400_0000)) : $urandom();
            queue_item(CMD_BEEP, 16'($urandom()), step, 24'(len), vol);
            counted++;
            drop_at = (len > 1 && $urandom_range(3) == 0) ? $urandom_range(len - 1, 1) : -1;
            n = len + 1 + $urandom_range(3);
            for (int k = 0; k < n; k++) begin
               if (k == drop_at) queue_noise_beep();
               queue_sample();
               counted++;
            end
         end else if ($urandom_range(1) == 0) begin
            n = $urandom_range(6, 1);
            for (int k = 0; k < n; k++) begin
               queue_sample();
               counted++;
            end
         end else begin
            len = $urandom_range(30, 2);
            queue_item(CMD_BEEP, 16'($urandom()), $urandom(), 24'(len), 8'($urandom()));
            counted++;
            for (int k = 0; k < len / 2; k++) begin
               queue_sample();
               counted++;
            end
         end
      end

      // Let any beep left sounding run out, then start one of the longest length.
      for (int k = 0; k < 305; k++) queue_sample();
      queue_item(CMD_BEEP, 16'($urandom()), $urandom(), 24'hff_ffff, 8'($urandom()));
      for (int k = 0; k < 20; k++) queue_sample();
      total_items = pending_items.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (!(pending_items.size() == 0 && !req_bus.valid && expected_mix.size() == 0));
      repeat (8) @(posedge clock);

      $display("Checked %0d results, %0d with tone, from %0d transfers in.",
               results_seen, tone_results, req_accepted);
      $display("Beeps started: %0d, start requests dropped while sounding: %0d.",
               beeps_started, beeps_dropped);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
